FILE: hdl/md5s_pkg.sv
// ----------------------------------------------------------------------------
// md5s_pkg
// Shared types, constants and round functions for the streaming md5 hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package md5s_pkg;

    localparam int unsigned CNT_W = 61;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [3:0][31:0] IV_WORDS = {IV_D, IV_C, IV_B, IV_A};

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // last word index that leaves room for the length in the same block
    localparam logic [3:0] LAST_DATA_WORD = 4'd13;
    localparam logic [3:0] LEN_LO_WORD    = 4'd14;
    localparam logic [3:0] LEN_HI_WORD    = 4'd15;
    localparam logic [5:0] LAST_ROUND     = 6'd63;
    localparam logic [5:0] LAST_BYTE_POS  = 6'd63;
    localparam logic [1:0] LAST_LANE      = 2'd3;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_COMP,
        ST_PAD,
        ST_PCOMP1,
        ST_PCOMP2,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic reinit;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    localparam logic [31:0] K_TAB [0:63] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // rotate amounts, indexed by {round group, round mod 4}
    localparam logic [4:0] S_TAB [0:15] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [31:0] round_const(input logic [5:0] r);
        return K_TAB[r];
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] r);
        return S_TAB[{r[5:4], r[1:0]}];
    endfunction

    // message word used by each round
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] lo;
        logic [3:0] idx;
        lo = r[3:0];
        case (r[5:4])
            2'd0: idx = lo;
            2'd1: idx = {lo[1:0], 2'b00} + lo + 4'd1;
            2'd2: idx = {lo[2:0], 1'b0} + lo + 4'd5;
            2'd3: idx = {lo[0], 3'b000} - lo;
            default: idx = lo;
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] round_fn(input logic [5:0] r, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (r[5:4])
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (b & d) | (c & ~d);
            2'd2: f = b ^ c ^ d;
            2'd3: f = c ^ (b | ~d);
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/md5s_buf.sv
// ----------------------------------------------------------------------------
// md5s_buf
// 16 x 32 block buffer, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module md5s_buf (
    input  wire logic        i_clk,
    input  wire logic        i_we,
    input  wire logic [3:0]  i_wr_addr,
    input  wire logic [31:0] i_wr_data,
    input  wire logic [3:0]  i_rd_addr,
    output logic      [31:0] o_rd_data
);

    logic [31:0] r_mem [0:15];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: hdl/md5s_core.sv
// ----------------------------------------------------------------------------
// md5s_core
// Compression engine: one md5 round per cycle, message words from the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module md5s_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire md5s_pkg::t_core_ctl   i_ctl,
    output md5s_pkg::t_core_sts        o_sts,
    output logic [3:0]                 o_rd_addr,
    input  wire logic [31:0]           i_rd_data,
    output logic [3:0][31:0]           o_chain
);

    logic             r_busy;
    logic             r_run;
    logic [5:0]       r_round;
    logic [31:0]      r_a, r_b, r_c, r_d;
    logic [3:0][31:0] r_chain;

    logic [31:0] w_f;
    logic [31:0] w_sum;
    logic [63:0] w_dbl;
    logic [31:0] w_new_b;
    logic        w_done;

    assign w_f     = md5s_pkg::round_fn(r_round, r_b, r_c, r_d);
    assign w_sum   = r_a + w_f + i_rd_data + md5s_pkg::round_const(r_round);
    assign w_dbl   = {w_sum, w_sum} << md5s_pkg::rot_amt(r_round);
    assign w_new_b = r_b + w_dbl[63:32];
    assign w_done  = r_run && (r_round == md5s_pkg::LAST_ROUND);

    // fetch one round ahead; the first fetch happens in the priming cycle
    assign o_rd_addr = r_run ? md5s_pkg::msg_index(r_round + 6'd1)
                             : md5s_pkg::msg_index(6'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_run   <= 1'b0;
            r_round <= '0;
            r_chain <= md5s_pkg::IV_WORDS;
        end else begin
            if (i_ctl.reinit) begin
                r_chain <= md5s_pkg::IV_WORDS;
            end
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_run   <= 1'b0;
                r_round <= '0;
            end else if (r_busy && !r_run) begin
                r_run <= 1'b1;
            end else if (r_run) begin
                r_round <= r_round + 6'd1;
                if (w_done) begin
                    r_busy     <= 1'b0;
                    r_run      <= 1'b0;
                    r_chain[0] <= r_chain[0] + r_d;
                    r_chain[1] <= r_chain[1] + w_new_b;
                    r_chain[2] <= r_chain[2] + r_b;
                    r_chain[3] <= r_chain[3] + r_c;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
        end else if (r_run) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= w_new_b;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = w_done;
    assign o_chain    = r_chain;

endmodule

`default_nettype wire

FILE: hdl/md5_stream_hash.sv
// ----------------------------------------------------------------------------
// md5_stream_hash
// Byte-serial md5 hasher: packs bytes into a block buffer, pads, compresses.
// ----------------------------------------------------------------------------
// loading: one byte word is taken per cycle while loading; a full block then
//   holds the input while the core primes its first fetch and runs 64 rounds, one round
//   per cycle out of the block buffer read port
// message end: 16 - (bytes mod 64)/4 padding writes, then a compression; with 8
//   or fewer bytes of room, 16 more writes and a second compression, then 4 digest words
// reset: chaining words go to the md5 initial values and the byte count to zero;
//   the block buffer is not cleared, every word is written before it is read
`default_nettype none

module md5_stream_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input byte stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] message_byte
    input  wire logic        i_s_axis_tuser,   // [0] has_byte
    input  wire logic        i_s_axis_tlast,   // message_last
    // digest stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [31:0] digest_word
    output logic             o_m_axis_tlast    // digest_last
);

    md5s_pkg::t_state    r_state, n_state;
    logic [md5s_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]         r_word, n_word;      // partial word, lower lanes valid
    logic                r_pad_pend, n_pad_pend;
    logic [3:0]          r_widx, n_widx;      // next padding word to write
    logic                r_first, n_first;    // next pad word carries 0x80
    logic                r_final, n_final;    // this block takes the length
    logic [1:0]          r_k, n_k;            // digest word index

    md5s_pkg::t_core_ctl w_ctl;
    md5s_pkg::t_core_sts w_sts;
    logic [3:0][31:0]    w_chain;
    logic [3:0]          w_rd_addr;
    logic [31:0]         w_rd_data;

    logic        w_we;
    logic [3:0]  w_wr_addr;
    logic [31:0] w_wr_data;

    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_byte_acc;
    logic [1:0]  w_lane;
    logic [4:0]  w_lane_sh;
    logic [31:0] w_byte_word;
    logic [31:0] w_pad80_word;
    logic [31:0] w_pad_data;
    logic [63:0] w_bits;
    logic        w_enter_pad;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc  = o_m_axis_tvalid && i_m_axis_tready;
    assign w_byte_acc = w_in_acc && i_s_axis_tuser;

    // byte lanes fill little-endian; lane zero starts a fresh word
    assign w_lane    = r_cnt[1:0];
    assign w_lane_sh = {w_lane, 3'b000};
    assign w_byte_word  = (w_lane == 2'd0) ? {24'd0, i_s_axis_tdata}
                        : (r_word | ({24'd0, i_s_axis_tdata} << w_lane_sh));
    assign w_pad80_word = (w_lane == 2'd0) ? {24'd0, md5s_pkg::PAD_BYTE}
                        : (r_word | ({24'd0, md5s_pkg::PAD_BYTE} << w_lane_sh));

    // message length in bits, modulo 2^64
    assign w_bits = {r_cnt, 3'b000};

    always_comb begin
        if (r_first) begin
            w_pad_data = w_pad80_word;
        end else if (r_final && (r_widx == md5s_pkg::LEN_LO_WORD)) begin
            w_pad_data = w_bits[31:0];
        end else if (r_final && (r_widx == md5s_pkg::LEN_HI_WORD)) begin
            w_pad_data = w_bits[63:32];
        end else begin
            w_pad_data = '0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            md5s_pkg::ST_LOAD: begin
                if (w_in_acc) begin
                    if (i_s_axis_tuser && (r_cnt[5:0] == md5s_pkg::LAST_BYTE_POS)) begin
                        n_state = md5s_pkg::ST_COMP;
                    end else if (i_s_axis_tlast) begin
                        n_state = md5s_pkg::ST_PAD;
                    end
                end
            end
            md5s_pkg::ST_COMP: begin
                if (w_sts.done) begin
                    n_state = r_pad_pend ? md5s_pkg::ST_PAD : md5s_pkg::ST_LOAD;
                end
            end
            md5s_pkg::ST_PAD: begin
                if (r_widx == md5s_pkg::LEN_HI_WORD) begin
                    n_state = r_final ? md5s_pkg::ST_PCOMP2 : md5s_pkg::ST_PCOMP1;
                end
            end
            md5s_pkg::ST_PCOMP1: begin
                if (w_sts.done) begin
                    n_state = md5s_pkg::ST_PAD;
                end
            end
            md5s_pkg::ST_PCOMP2: begin
                if (w_sts.done) begin
                    n_state = md5s_pkg::ST_OUT;
                end
            end
            md5s_pkg::ST_OUT: begin
                if (w_out_acc && (r_k == 2'd3)) begin
                    n_state = md5s_pkg::ST_LOAD;
                end
            end
            default: n_state = md5s_pkg::ST_LOAD;
        endcase
    end

    // datapath registers
    assign w_enter_pad = (n_state == md5s_pkg::ST_PAD) && (r_state != md5s_pkg::ST_PAD);

    always_comb begin
        n_cnt      = r_cnt;
        n_word     = r_word;
        n_pad_pend = r_pad_pend;
        n_widx     = r_widx;
        n_first    = r_first;
        n_final    = r_final;
        n_k        = r_k;

        if (w_byte_acc) begin
            n_cnt  = r_cnt + 61'd1;
            n_word = w_byte_word;
        end
        if ((r_state == md5s_pkg::ST_LOAD) && w_in_acc) begin
            n_pad_pend = i_s_axis_tlast;
        end

        if (r_state == md5s_pkg::ST_PAD) begin
            n_widx  = r_widx + 4'd1;
            n_first = 1'b0;
        end
        if (w_enter_pad) begin
            if (r_state == md5s_pkg::ST_PCOMP1) begin
                // overflow block: length goes in a fresh block of zeros
                n_widx  = '0;
                n_first = 1'b0;
                n_final = 1'b1;
            end else begin
                n_widx  = n_cnt[5:2];
                n_first = 1'b1;
                n_final = (n_cnt[5:2] <= md5s_pkg::LAST_DATA_WORD);
            end
        end

        if (r_state != md5s_pkg::ST_OUT) begin
            n_k = '0;
        end else if (w_out_acc) begin
            n_k = r_k + 2'd1;
            if (r_k == 2'd3) begin
                n_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= md5s_pkg::ST_LOAD;
            r_cnt      <= '0;
            r_pad_pend <= 1'b0;
            r_widx     <= '0;
            r_first    <= 1'b0;
            r_final    <= 1'b0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_pad_pend <= n_pad_pend;
            r_widx     <= n_widx;
            r_first    <= n_first;
            r_final    <= n_final;
            r_k        <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    // outputs and control
    always_comb begin
        o_s_axis_tready = (r_state == md5s_pkg::ST_LOAD);
        o_m_axis_tvalid = (r_state == md5s_pkg::ST_OUT);
        o_m_axis_tdata  = w_chain[r_k];
        o_m_axis_tlast  = (r_k == 2'd3);

        w_we      = 1'b0;
        w_wr_addr = r_cnt[5:2];
        w_wr_data = w_byte_word;
        if (r_state == md5s_pkg::ST_PAD) begin
            w_we      = 1'b1;
            w_wr_addr = r_widx;
            w_wr_data = w_pad_data;
        end else if (w_byte_acc && (w_lane == md5s_pkg::LAST_LANE)) begin
            w_we = 1'b1;
        end

        // a full block, or the last padding word, kicks off a compression
        w_ctl.start  = ((r_state == md5s_pkg::ST_LOAD) && (n_state == md5s_pkg::ST_COMP))
                    || ((r_state == md5s_pkg::ST_PAD) && (r_widx == md5s_pkg::LEN_HI_WORD));
        w_ctl.reinit = (r_state == md5s_pkg::ST_OUT) && w_out_acc && (r_k == 2'd3);
    end

    md5s_buf u_buf (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    md5s_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .o_sts     (w_sts),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_chain   (w_chain)
    );

    // the buffer is never written while rounds read it
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !w_sts.busy)
        else $error("block buffer written during compression");

    // a compression starts only on an idle engine
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.start |-> !w_sts.busy)
        else $error("compression started while engine busy");

    // a full-block compression always sits on a 64-byte boundary
    a_comp_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == md5s_pkg::ST_COMP) |-> (r_cnt[5:0] == 6'd0))
        else $error("block compressed off a block boundary");

    // after the final digest word the block is back to taking bytes with a clear count
    a_digest_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_m_axis_tlast) |=> (o_s_axis_tready && (r_cnt == '0)))
        else $error("hasher not reset after digest");

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte-serial md5 hasher. Message bytes go in one
// word at a time. An md5 model inside the bench works out every digest. Each
// digest word that comes out is compared with the oldest one still due. The
// bench runs short directed messages first, then random messages under
// several sender and receiver idle patterns.
// ----------------------------------------------------------------------------

module tb;

    // one digest word as it should leave the block
    typedef struct {
        logic [31:0] word;
        logic        last;
    } t_digest;

    // md5 additive constants, one per round
    localparam logic [31:0] ROUND_ADD [0:63] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // left rotate amounts, four per round group
    localparam int unsigned ROT_BY [0:15] = '{
        7, 12, 17, 22,
        5, 9,  14, 20,
        4, 11, 16, 23,
        6, 10, 15, 21
    };

    // message lengths around the padding and block boundaries
    localparam int unsigned BOUNDARY_LENS [0:10] = '{
        55, 56, 57, 63, 64, 65, 119, 120, 121, 127, 128
    };

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // byte stream into the block
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = '0;     // [7:0] message_byte
    logic       s_tuser  = 1'b0;   // [0] has_byte
    logic       s_tlast  = 1'b0;   // message_last

    // digest stream out of the block
    logic        m_tready = 1'b0;
    logic        m_tvalid;
    logic [31:0] m_tdata;          // [31:0] digest_word
    logic        m_tlast;          // digest_last
    logic        s_tready;

    // idle percentages for the sender and the receiver
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;

    // md5 model state
    logic [31:0] md_chain [0:3];
    logic [31:0] md_block [0:15];
    logic [60:0] md_count;

    // digest words still to come, oldest first
    t_digest digest_due [$];
    int      fail_count = 0;

    md5_stream_hash dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // md5 model
    // ------------------------------------------------------------------------

    // back to the initial chaining values, empty block, zero length
    function automatic void md5_restart();
        md_chain[0] = 32'h67452301;
        md_chain[1] = 32'hEFCDAB89;
        md_chain[2] = 32'h98BADCFE;
        md_chain[3] = 32'h10325476;
        for (int i = 0; i < 16; i++) md_block[i] = '0;
        md_count = '0;
    endfunction

    // 64 rounds over the block, fold into the chain, clear the block
    function automatic void md5_compress();
        logic [31:0] a, b, c, d, f, t;
        int unsigned g, s;
        a = md_chain[0];
        b = md_chain[1];
        c = md_chain[2];
        d = md_chain[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * r + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            s = ROT_BY[(r / 16) * 4 + r % 4];
            t = a + f + md_block[g] + ROUND_ADD[r];
            t = b + ((t << s) | (t >> (32 - s)));
            a = d;
            d = c;
            c = b;
            b = t;
        end
        md_chain[0] += a;
        md_chain[1] += b;
        md_chain[2] += c;
        md_chain[3] += d;
        for (int i = 0; i < 16; i++) md_block[i] = '0;
    endfunction

    // take one accepted word; on message end pad, finish and queue the digest
    function automatic void md5_absorb(logic [7:0] msg_byte, logic has_byte, logic msg_last);
        int unsigned pos;
        logic [63:0] bit_len;
        t_digest     d;
        if (has_byte) begin
            pos = md_count[5:0];
            md_block[pos / 4] |= 32'(msg_byte) << (8 * (pos % 4));
            md_count = md_count + 61'd1;
            if (md_count[5:0] == 6'd0) md5_compress();
        end
        if (!msg_last) return;
        // pad byte, then the bit length in the last two words
        pos = md_count[5:0];
        bit_len = {md_count, 3'b000};
        md_block[pos / 4] |= 32'h80 << (8 * (pos % 4));
        if (pos + 1 > 56) md5_compress();
        md_block[14] = bit_len[31:0];
        md_block[15] = bit_len[63:32];
        md5_compress();
        for (int k = 0; k < 4; k++) begin
            d.word = md_chain[k];
            d.last = (k == 3);
            digest_due.push_back(d);
        end
        md5_restart();
    endfunction

    // ------------------------------------------------------------------------
    // stimulus side
    // ------------------------------------------------------------------------

    // one word to the block; random gaps first, model updated on acceptance
    task automatic send_word(input logic [7:0] msg_byte, input logic has_byte,
                             input logic msg_last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= msg_byte;
        s_tuser  <= has_byte;
        s_tlast  <= msg_last;
        do @(posedge clk); while (!s_tready);
        md5_absorb(msg_byte, has_byte, msg_last);
    endtask

    // receiver stalls at random; percentage set per phase
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // digest checker
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : check_digest
        t_digest want;
        if (rst_n && m_tvalid && m_tready) begin
            if (digest_due.size() == 0) begin
                $error("digest_word: none expected, actual %h", m_tdata);
                fail_count++;
            end else begin
                want = digest_due.pop_front();
                if (m_tdata !== want.word) begin
                    $error("digest_word: expected %h, actual %h", want.word, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("digest_last: expected %b, actual %b", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // empty message, also right after a word with no byte, and twice in a row
    task automatic test_empty_message();
        send_word(8'hA5, 1'b0, 1'b0);
        send_word(8'h5A, 1'b0, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);
    endtask

    // byte carried on the closing word, and a closing word with no byte
    task automatic test_message_end();
        send_word("a", 1'b1, 1'b0);
        send_word("b", 1'b1, 1'b0);
        send_word("c", 1'b1, 1'b1);
        send_word("a", 1'b1, 1'b0);
        send_word("b", 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
    endtask

    // all-zero and all-one bytes, with an ignored word inside a message
    task automatic test_byte_extremes();
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);
    endtask

    // random messages: mostly short, some on block boundaries, a few long;
    // ignored words sprinkled in, some messages closed by an empty word
    task automatic test_random_messages(input int unsigned src_pct,
                                        input int unsigned sink_pct,
                                        input int n_words);
        int sent;
        int unsigned pick, len;
        logic split_last;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        sent = 0;
        while (sent < n_words) begin
            pick = $urandom_range(99);
            if (pick < 65)
                len = $urandom_range(12);
            else if (pick < 90)
                len = BOUNDARY_LENS[$urandom_range(10)];
            else
                len = $urandom_range(140, 13);
            split_last = (len == 0) || ($urandom_range(99) < 30);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(99) < 6)
                    send_word(8'($urandom_range(255)), 1'b0, 1'b0);
                send_word(8'($urandom_range(255)), 1'b1, !split_last && (i == len - 1));
                sent++;
            end
            if (split_last) begin
                send_word(8'($urandom_range(255)), 1'b0, 1'b1);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------------
    initial begin
        md5_restart();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_message();
        test_message_end();
        test_byte_extremes();

        // no idling, idling sender, stalling receiver, then both
        test_random_messages(0, 0, 120);
        test_random_messages(76, 0, 120);
        test_random_messages(0, 76, 120);
        test_random_messages(33, 33, 120);

        s_tvalid <= 1'b0;
        while (digest_due.size() != 0) @(posedge clk);
        // let any stray output show up
        repeat (150) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
hdl/md5s_pkg.sv
hdl/md5s_buf.sv
hdl/md5s_core.sv
hdl/md5_stream_hash.sv
bench/tb.sv
